// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/tked_pkg.sv
// Types and constants for the terminal key escape decoder.
package tked_pkg;

    localparam int unsigned TIMEOUT_W = 24;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd150000;

    // Parser phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ESC     = 2'd1,
        PH_BRACKET = 2'd2,
        PH_SWALLOW = 2'd3
    } phase_t;

    // Key event codes
    typedef enum logic [3:0] {
        EV_NONE  = 4'd0,
        EV_UP    = 4'd1,
        EV_DOWN  = 4'd2,
        EV_RIGHT = 4'd3,
        EV_LEFT  = 4'd4,
        EV_HOME  = 4'd5,
        EV_END   = 4'd6,
        EV_PGUP  = 4'd7,
        EV_PGDN  = 4'd8,
        EV_DEL   = 4'd9,
        EV_MENU  = 4'd10,
        EV_COPY  = 4'd11,
        EV_PASTE = 4'd12,
        EV_FILES = 4'd13,
        EV_CHAR  = 4'd14
    } event_t;

    // Item op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Byte values
    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_CTRL_T  = 8'h14;
    localparam logic [7:0] BYTE_CTRL_C  = 8'h03;
    localparam logic [7:0] BYTE_CTRL_V  = 8'h16;
    localparam logic [7:0] BYTE_CTRL_F  = 8'h06;
    localparam logic [7:0] BYTE_BRACKET = 8'h5B;
    localparam logic [7:0] BYTE_A       = 8'h41;
    localparam logic [7:0] BYTE_B       = 8'h42;
    localparam logic [7:0] BYTE_C       = 8'h43;
    localparam logic [7:0] BYTE_D       = 8'h44;
    localparam logic [7:0] BYTE_H       = 8'h48;
    localparam logic [7:0] BYTE_F       = 8'h46;
    localparam logic [7:0] BYTE_1       = 8'h31;
    localparam logic [7:0] BYTE_3       = 8'h33;
    localparam logic [7:0] BYTE_4       = 8'h34;
    localparam logic [7:0] BYTE_5       = 8'h35;
    localparam logic [7:0] BYTE_6       = 8'h36;
    localparam logic [7:0] BYTE_7       = 8'h37;
    localparam logic [7:0] BYTE_8       = 8'h38;

    // One input item
    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } item_t;

    // One result item
    typedef struct packed {
        event_t     event_code;
        logic [7:0] char_value;
    } result_t;

endpackage

// File: rtl/tked_parser.sv
// Escape parser: phase and tick-count state plus the per-item decode logic.
`include "assert_macros.svh"

module tked_parser #(
    parameter int unsigned TICK_COUNT_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  tked_pkg::item_t                     item,
    input  logic [tked_pkg::TIMEOUT_W-1:0]      timeout,
    output tked_pkg::result_t                   result
);

    localparam int unsigned CMP_W = (TICK_COUNT_WIDTH > tked_pkg::TIMEOUT_W) ?
                                    TICK_COUNT_WIDTH : tked_pkg::TIMEOUT_W;

    tked_pkg::phase_t              phase_reg, phase_next;
    logic [TICK_COUNT_WIDTH-1:0]   elapsed_reg, elapsed_next;
    logic [TICK_COUNT_WIDTH-1:0]   elapsed_inc;
    logic                          timed_out;

    // Saturating tick count and timeout compare
    assign elapsed_inc = (elapsed_reg == {TICK_COUNT_WIDTH{1'b1}}) ?
                         elapsed_reg : elapsed_reg + TICK_COUNT_WIDTH'(1);
    assign timed_out   = CMP_W'(elapsed_inc) > CMP_W'(timeout);

    // Next state and event for the item in hand
    always_comb
    begin
        phase_next        = phase_reg;
        elapsed_next      = elapsed_reg;
        result.event_code = tked_pkg::EV_NONE;
        result.char_value = 8'd0;
        if (item.op == tked_pkg::OP_TICK)
        begin
            elapsed_next = elapsed_inc;
            if (phase_reg == tked_pkg::PH_ESC && timed_out)
            begin
                phase_next        = tked_pkg::PH_IDLE;
                result.event_code = tked_pkg::EV_MENU;
            end
        end
        else
        begin
            case (phase_reg)
                tked_pkg::PH_SWALLOW:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                end
                tked_pkg::PH_BRACKET:
                begin
                    phase_next = tked_pkg::PH_IDLE;
                    case (item.byte_value)
                        tked_pkg::BYTE_A: result.event_code = tked_pkg::EV_UP;
                        tked_pkg::BYTE_B: result.event_code = tked_pkg::EV_DOWN;
                        tked_pkg::BYTE_C: result.event_code = tked_pkg::EV_RIGHT;
                        tked_pkg::BYTE_D: result.event_code = tked_pkg::EV_LEFT;
                        tked_pkg::BYTE_H: result.event_code = tked_pkg::EV_HOME;
                        tked_pkg::BYTE_F: result.event_code = tked_pkg::EV_END;
                        tked_pkg::BYTE_1, tked_pkg::BYTE_7:
                        begin
                            result.event_code = tked_pkg::EV_HOME;
                            phase_next        = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_4, tked_pkg::BYTE_8:
                        begin
                            result.event_code = tked_pkg::EV_END;
                            phase_next        = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_5:
                        begin
                            result.event_code = tked_pkg::EV_PGUP;
                            phase_next        = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_6:
                        begin
                            result.event_code = tked_pkg::EV_PGDN;
                            phase_next        = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_3:
                        begin
                            result.event_code = tked_pkg::EV_DEL;
                            phase_next        = tked_pkg::PH_SWALLOW;
                        end
                        default: ;  // unknown final byte is dropped
                    endcase
                end
                tked_pkg::PH_ESC:
                begin
                    if (item.byte_value == tked_pkg::BYTE_BRACKET)
                        phase_next = tked_pkg::PH_BRACKET;
                    else
                    begin
                        // lone escape resolved by any other byte; that byte is lost
                        phase_next        = tked_pkg::PH_IDLE;
                        result.event_code = tked_pkg::EV_MENU;
                    end
                end
                default:
                begin
                    case (item.byte_value)
                        tked_pkg::BYTE_ESC:
                        begin
                            phase_next   = tked_pkg::PH_ESC;
                            elapsed_next = '0;
                        end
                        tked_pkg::BYTE_CTRL_T: result.event_code = tked_pkg::EV_MENU;
                        tked_pkg::BYTE_CTRL_C: result.event_code = tked_pkg::EV_COPY;
                        tked_pkg::BYTE_CTRL_V: result.event_code = tked_pkg::EV_PASTE;
                        tked_pkg::BYTE_CTRL_F: result.event_code = tked_pkg::EV_FILES;
                        default:
                        begin
                            result.event_code = tked_pkg::EV_CHAR;
                            result.char_value = item.byte_value;
                        end
                    endcase
                end
            endcase
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tked_pkg::PH_IDLE;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // A tick outside the escape phase never moves the parser
    `ASSERT_PROP(a_tick_keeps_phase, clk, rst_n,
        step && item.op == tked_pkg::OP_TICK && phase_reg != tked_pkg::PH_ESC
        |=> $stable(phase_reg))
    // ESC while idle arms the parser with a cleared count
    `ASSERT_PROP(a_esc_arms, clk, rst_n,
        step && item.op == tked_pkg::OP_BYTE && phase_reg == tked_pkg::PH_IDLE &&
        item.byte_value == tked_pkg::BYTE_ESC
        |=> phase_reg == tked_pkg::PH_ESC && elapsed_reg == '0)
    // Character data only accompanies a char event
    `ASSERT_ALWAYS(a_char_zero, clk, rst_n,
        result.event_code == tked_pkg::EV_CHAR || result.char_value == 8'd0)
    // Without a step the state holds
    `ASSERT_PROP(a_hold_without_step, clk, rst_n,
        !step |=> $stable(phase_reg) && $stable(elapsed_reg))

endmodule

// File: rtl/terminal_key_escape_decoder_top.sv
// Terminal key escape decoder: input register, parser and result register.
// Flow: an item transfers into the input register, then its result enters the
//   result register; one item per cycle sustained, limited by the single
//   parser state update per cycle; a held result stalls the input stage.
// Reset (rst_n, async low): parser idle, tick count zero, timeout 150000,
//   both pipeline registers empty.
`include "assert_macros.svh"

module terminal_key_escape_decoder_top #(
    parameter int unsigned TICK_COUNT_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            op,
    input  logic [7:0]                      byte_value,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [3:0]                      event_code,
    output logic [7:0]                      char_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tked_pkg::TIMEOUT_W-1:0]  escape_timeout_ticks
);

    logic                               in_valid_reg;
    tked_pkg::item_t                    in_item_reg;
    logic                               out_valid_reg;
    tked_pkg::result_t                  out_result_reg;
    tked_pkg::result_t                  result_next;
    logic [tked_pkg::TIMEOUT_W-1:0]     timeout_reg;
    logic                               advance;

    // Pipeline flow: stage moves whenever the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= tked_pkg::TIMEOUT_RESET;
        else if (cfg_valid)
            timeout_reg <= escape_timeout_ticks;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg.op         <= op;
            in_item_reg.byte_value <= byte_value;
        end
    end

    // Decode
    tked_parser #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .timeout (timeout_reg),
        .result  (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign event_code   = out_result_reg.event_code;
    assign char_value   = out_result_reg.char_value;

    // Each processed item lands in the result register
    `ASSERT_PROP(a_advance_fills, clk, rst_n, advance |=> out_valid_reg)
    // A held result blocks the parser
    `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n,
        !(out_valid_reg && !result_ready && advance))
    // A full input stage with a blocked output refuses new items
    `ASSERT_ALWAYS(a_stall_backpressure, clk, rst_n,
        !(in_valid_reg && out_valid_reg && !result_ready && item_ready))

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the terminal key escape decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W = 24;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    logic op;
    logic [7:0] byte_value;
    logic result_valid;
    logic result_ready;
    logic [3:0] event_code;
    logic [7:0] char_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [tked_pkg::TIMEOUT_W-1:0] escape_timeout_ticks;

    // Predictor state: parser phase, ticks since ESC, programmed timeout
    tked_pkg::phase_t kb_phase;
    logic [COUNT_W-1:0] esc_ticks;
    logic [tked_pkg::TIMEOUT_W-1:0] esc_timeout;

    tked_pkg::result_t expected_keys[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    terminal_key_escape_decoder_top #(
        .TICK_COUNT_WIDTH(COUNT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .op(op),
        .byte_value(byte_value),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .event_code(event_code),
        .char_value(char_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .escape_timeout_ticks(escape_timeout_ticks)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver back-pressure, changed at the falling edge
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Expected key event for one item; advances the predictor state
    function automatic tked_pkg::result_t decode_key(input tked_pkg::item_t it);
        tked_pkg::result_t r;
        r.event_code = tked_pkg::EV_NONE;
        r.char_value = 8'h00;
        if (it.op == tked_pkg::OP_TICK)
        begin
            if (esc_ticks != '1)
                esc_ticks = esc_ticks + 1'b1;
            if (kb_phase == tked_pkg::PH_ESC && esc_ticks > esc_timeout)
            begin
                kb_phase = tked_pkg::PH_IDLE;
                r.event_code = tked_pkg::EV_MENU;
            end
        end
        else
        begin
            case (kb_phase)
                tked_pkg::PH_SWALLOW:
                    kb_phase = tked_pkg::PH_IDLE;
                tked_pkg::PH_BRACKET:
                begin
                    kb_phase = tked_pkg::PH_IDLE;
                    case (it.byte_value)
                        tked_pkg::BYTE_A: r.event_code = tked_pkg::EV_UP;
                        tked_pkg::BYTE_B: r.event_code = tked_pkg::EV_DOWN;
                        tked_pkg::BYTE_C: r.event_code = tked_pkg::EV_RIGHT;
                        tked_pkg::BYTE_D: r.event_code = tked_pkg::EV_LEFT;
                        tked_pkg::BYTE_H: r.event_code = tked_pkg::EV_HOME;
                        tked_pkg::BYTE_F: r.event_code = tked_pkg::EV_END;
                        tked_pkg::BYTE_1, tked_pkg::BYTE_7:
                        begin
                            r.event_code = tked_pkg::EV_HOME;
                            kb_phase = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_4, tked_pkg::BYTE_8:
                        begin
                            r.event_code = tked_pkg::EV_END;
                            kb_phase = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_5:
                        begin
                            r.event_code = tked_pkg::EV_PGUP;
                            kb_phase = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_6:
                        begin
                            r.event_code = tked_pkg::EV_PGDN;
                            kb_phase = tked_pkg::PH_SWALLOW;
                        end
                        tked_pkg::BYTE_3:
                        begin
                            r.event_code = tked_pkg::EV_DEL;
                            kb_phase = tked_pkg::PH_SWALLOW;
                        end
                        default:
                            ;
                    endcase
                end
                tked_pkg::PH_ESC:
                begin
                    if (it.byte_value == tked_pkg::BYTE_BRACKET)
                        kb_phase = tked_pkg::PH_BRACKET;
                    else
                    begin
                        kb_phase = tked_pkg::PH_IDLE;
                        r.event_code = tked_pkg::EV_MENU;
                    end
                end
                default:
                begin
                    case (it.byte_value)
                        tked_pkg::BYTE_ESC:
                        begin
                            kb_phase = tked_pkg::PH_ESC;
                            esc_ticks = '0;
                        end
                        tked_pkg::BYTE_CTRL_T: r.event_code = tked_pkg::EV_MENU;
                        tked_pkg::BYTE_CTRL_C: r.event_code = tked_pkg::EV_COPY;
                        tked_pkg::BYTE_CTRL_V: r.event_code = tked_pkg::EV_PASTE;
                        tked_pkg::BYTE_CTRL_F: r.event_code = tked_pkg::EV_FILES;
                        default:
                        begin
                            r.event_code = tked_pkg::EV_CHAR;
                            r.char_value = it.byte_value;
                        end
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] cursor_final(input int k);
        case (k)
            0: return tked_pkg::BYTE_A;
            1: return tked_pkg::BYTE_B;
            2: return tked_pkg::BYTE_C;
            3: return tked_pkg::BYTE_D;
            4: return tked_pkg::BYTE_H;
            default: return tked_pkg::BYTE_F;
        endcase
    endfunction

    function automatic logic [7:0] edit_digit(input int k);
        case (k)
            0: return tked_pkg::BYTE_1;
            1: return tked_pkg::BYTE_4;
            2: return tked_pkg::BYTE_7;
            3: return tked_pkg::BYTE_8;
            4: return tked_pkg::BYTE_5;
            5: return tked_pkg::BYTE_6;
            default: return tked_pkg::BYTE_3;
        endcase
    endfunction

    // One item transfer; called and returns at a falling edge
    task automatic send_key(input logic op_i, input logic [7:0] b_i);
        tked_pkg::item_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        op <= op_i;
        byte_value <= b_i;
        do
            @(posedge clk);
        while (!item_ready);
        it.op = op_i;
        it.byte_value = b_i;
        expected_keys.push_back(decode_key(it));
        @(negedge clk);
    endtask

    // Hold the sender off until every expected event has come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write, only with the decoder idle
    task automatic set_timeout(input logic [tked_pkg::TIMEOUT_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        escape_timeout_ticks <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        esc_timeout = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Byte extremes, control keys and a tick while idle
    task automatic test_plain_bytes();
        send_key(tked_pkg::OP_BYTE, 8'h00);
        send_key(tked_pkg::OP_BYTE, 8'hFF);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_CTRL_T);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_CTRL_C);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_CTRL_V);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_CTRL_F);
        send_key(tked_pkg::OP_TICK, 8'hA5);
    endtask

    // Cursor, edit, unknown and broken escape sequences
    task automatic test_escape_sequences();
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_A);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_5);
        send_key(tked_pkg::OP_BYTE, BYTE_TILDE);
        // unknown final byte is dropped
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
        send_key(tked_pkg::OP_BYTE, 8'h5A);
        // second ESC gives menu instead of a new sequence
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        // the swallowed byte may be an ESC
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_3);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_BYTE, 8'h71);
    endtask

    // Lone ESC timing out, and ESC clearing ticks counted while idle
    task automatic test_escape_timeout();
        set_timeout(24'd1);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_TICK, 8'h00);
        send_key(tked_pkg::OP_TICK, 8'hFF);
        send_key(tked_pkg::OP_TICK, 8'h00);
        send_key(tked_pkg::OP_TICK, 8'h00);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
        send_key(tked_pkg::OP_TICK, 8'h00);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
        send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_D);
    endtask

    // Mostly well-formed sequences with random content, plus noise
    task automatic test_random_traffic(input int n_items,
                                       input logic [tked_pkg::TIMEOUT_W-1:0] tmo,
                                       input int s_pct, input int r_pct);
        int sent;
        int kind;
        int n_ticks;
        int max_ticks;
        bit paused;
        logic [7:0] b;
        set_timeout(tmo);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        max_ticks = (tmo < 24'd16) ? int'(tmo) + 2 : 6;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            if (!paused && sent >= n_items / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 22)
            begin
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
                send_key(tked_pkg::OP_BYTE, cursor_final($urandom_range(5)));
                sent += 3;
            end
            else if (kind < 40)
            begin
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
                send_key(tked_pkg::OP_BYTE, edit_digit($urandom_range(6)));
                b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : BYTE_TILDE;
                send_key(tked_pkg::OP_BYTE, b);
                sent += 4;
            end
            else if (kind < 55)
            begin
                // lone ESC, some ticks, maybe a following byte
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
                n_ticks = $urandom_range(max_ticks);
                repeat (n_ticks) send_key(tked_pkg::OP_TICK, 8'($urandom_range(255)));
                sent += 1 + n_ticks;
                if ($urandom_range(1) == 1)
                begin
                    send_key(tked_pkg::OP_BYTE, 8'($urandom_range(255)));
                    sent += 1;
                end
            end
            else if (kind < 62)
            begin
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
                send_key(tked_pkg::OP_BYTE, 8'($urandom_range(255)));
                sent += 2;
            end
            else if (kind < 70)
            begin
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_ESC);
                send_key(tked_pkg::OP_BYTE, tked_pkg::BYTE_BRACKET);
                send_key(tked_pkg::OP_BYTE, 8'($urandom_range(255)));
                sent += 3;
            end
            else if (kind < 80)
            begin
                case ($urandom_range(3))
                    0: b = tked_pkg::BYTE_CTRL_T;
                    1: b = tked_pkg::BYTE_CTRL_C;
                    2: b = tked_pkg::BYTE_CTRL_V;
                    default: b = tked_pkg::BYTE_CTRL_F;
                endcase
                send_key(tked_pkg::OP_BYTE, b);
                sent += 1;
            end
            else if (kind < 92)
            begin
                send_key(tked_pkg::OP_BYTE, 8'($urandom_range(255)));
                sent += 1;
            end
            else
            begin
                send_key(tked_pkg::OP_TICK, 8'($urandom_range(255)));
                sent += 1;
            end
        end
        wait_drained();
    endtask

    // Compare each result transfer with the oldest expected event
    always @(posedge clk)
    begin
        tked_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_keys.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected result: event %0d char %02h",
                             event_code, char_value);
                error_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (event_code !== want.event_code || char_value !== want.char_value)
                begin
                    if (error_count < 10)
                        $display("mismatch: expected event %0d char %02h, got event %0d char %02h",
                                 want.event_code, want.char_value, event_code, char_value);
                    error_count++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        op = tked_pkg::OP_BYTE;
        byte_value = 8'h00;
        cfg_valid = 1'b0;
        escape_timeout_ticks = tked_pkg::TIMEOUT_RESET;
        kb_phase = tked_pkg::PH_IDLE;
        esc_ticks = '0;
        esc_timeout = tked_pkg::TIMEOUT_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 46;
        test_plain_bytes();
        test_escape_sequences();
        test_escape_timeout();
        test_random_traffic(220, 24'd1, 16, 46);
        test_random_traffic(220, 24'($urandom_range(2, 12)), 46, 16);
        test_random_traffic(220, 24'hFFFFFF, 0, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_keys.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/tked_pkg.sv
rtl/tked_parser.sv
rtl/terminal_key_escape_decoder_top.sv
verif/testbench.sv
